@@ sv/rmd_pkg.sv @@
// Shared types and constants for the ROI median depth block.
package rmd_pkg;

	// Pixel and register width in millimetres
	localparam int DW = 16;
	// Width of the reported kept count
	localparam int KW = 9;
	// Default store capacity
	localparam int MAX_SAMPLES_DEF = 256;

	// Configuration register indexes
	localparam int CFG_IW = 1;
	localparam logic [CFG_IW-1:0] REG_MIN_DEPTH = 1'b0;
	localparam logic [CFG_IW-1:0] REG_MAX_DEPTH = 1'b1;

	// Register reset values
	localparam logic [DW-1:0] MIN_DEPTH_RST = 16'd10;
	localparam logic [DW-1:0] MAX_DEPTH_RST = 16'd10000;

	// Per-cycle command broadcast to every cell of the sort chain
	typedef struct packed {
		logic          ins;  // insert din at its sorted place
		logic          shl;  // shift the whole chain one cell toward the head
		logic [DW-1:0] din;  // pixel being inserted
	} cell_ctl_t;

endpackage

@@ sv/rmd_if.sv @@
// Valid/ready channels for pixel items and result items.
interface rmd_in_if
	import rmd_pkg::*;
	;
	logic          valid;
	logic          ready;
	logic [DW-1:0] depth_px;
	logic          last_pixel;

	modport source (output valid, output depth_px, output last_pixel, input ready);
	modport sink   (input valid, input depth_px, input last_pixel, output ready);
endinterface

interface rmd_out_if
	import rmd_pkg::*;
	;
	logic          valid;
	logic          ready;
	logic [DW-1:0] median_depth_mm;
	logic          has_depth;
	logic [KW-1:0] kept_count;
	logic          overflowed;

	modport source (output valid, output median_depth_mm, output has_depth,
		output kept_count, output overflowed, input ready);
	modport sink   (input valid, input median_depth_mm, input has_depth,
		input kept_count, input overflowed, output ready);
endinterface

@@ sv/rmd_cell.sv @@
// One cell of the insertion-sort chain: holds one sorted entry.
module rmd_cell
	import rmd_pkg::*;
#(
	parameter int IDX = 0,
	parameter int CW  = 9
) (
	input  logic          clk,
	input  cell_ctl_t     ctl,
	input  logic [CW-1:0] count,
	input  logic [DW-1:0] left_q,
	input  logic          left_gt,
	input  logic [DW-1:0] right_q,
	output logic [DW-1:0] q,
	output logic          gt
);

	localparam logic [CW-1:0] IDX_C = CW'(IDX);

	logic occ;

	// An empty cell acts as +infinity so it always takes a value
	assign occ = IDX_C < count;
	assign gt  = !occ || (q > ctl.din);

	// Insert: a cell above the new value takes its left neighbor,
	// the first such cell takes the new value itself.
	always_ff @(posedge clk) begin
		if (ctl.shl) begin
			q <= right_q;
		end else if (ctl.ins && gt) begin
			q <= left_gt ? left_q : ctl.din;
		end
	end

endmodule

@@ sv/rmd_chain.sv @@
// Row of sort cells; cell 0 holds the smallest kept pixel.
module rmd_chain
	import rmd_pkg::*;
#(
	parameter int N  = MAX_SAMPLES_DEF,
	parameter int CW = $clog2(N + 1)
) (
	input  logic          clk,
	input  cell_ctl_t     ctl,
	input  logic [CW-1:0] count,
	output logic [DW-1:0] head_q
);

	logic [DW-1:0] val [N];
	logic          gtv [N];

	for (genvar i = 0; i < N; i++) begin : g_cell
		logic [DW-1:0] lq;
		logic          lg;
		logic [DW-1:0] rq;

		// Edge cells: nothing below the head, the tail refills with itself
		if (i == 0) begin : g_head
			assign lq = '0;
			assign lg = 1'b0;
		end else begin : g_mid
			assign lq = val[i-1];
			assign lg = gtv[i-1];
		end
		if (i == N - 1) begin : g_tail
			assign rq = val[i];
		end else begin : g_body
			assign rq = val[i+1];
		end

		rmd_cell #(
			.IDX (i),
			.CW  (CW)
		) u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.count   (count),
			.left_q  (lq),
			.left_gt (lg),
			.right_q (rq),
			.q       (val[i]),
			.gt      (gtv[i])
		);
	end

	assign head_q = val[0];

endmodule

@@ sv/roi_median_depth.sv @@
// Top level: depth gate, sort chain control and result register.
// Takes one depth pixel per cycle, except while draining, into a chain of
// sort cells. A pixel strictly between the two thresholds is inserted in
// sorted order in the cycle it is accepted; a pixel that finds all
// MAX_SAMPLES cells full is dropped and flagged. After the last pixel of a
// region the chain shifts toward its head k/2 times (k = pixels kept), one
// cell per cycle, so the upper median lands in cell 0; the result is then
// loaded into the output register and input resumes. A pending result
// does not block the pixels of the next region, only the drain of its
// last pixel.
module roi_median_depth
	import rmd_pkg::*;
#(
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_idx,
	input  logic [DW-1:0]     cfg_wdata,
	rmd_in_if.sink            pixel,
	rmd_out_if.source         result
);

	localparam int CW = $clog2(MAX_SAMPLES + 1);
	localparam logic [CW-1:0] CAP = CW'(MAX_SAMPLES);

	localparam logic ST_RUN   = 1'b0;
	localparam logic ST_DRAIN = 1'b1;

	logic [DW-1:0] min_q, max_q;
	logic          state_q;
	logic [CW-1:0] count_q, count_nxt, shl_cnt_q;
	logic          ovf_q;
	logic          out_vld_q;
	logic [DW-1:0] out_med_q;
	logic          out_has_q;
	logic [KW-1:0] out_cnt_q;
	logic          out_ovf_q;

	logic          acc, pass, full, ins, drain_done, load;
	cell_ctl_t     ctl;
	logic [DW-1:0] head;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= MIN_DEPTH_RST;
			max_q <= MAX_DEPTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_MIN_DEPTH: min_q <= cfg_wdata;
				REG_MAX_DEPTH: max_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Gate and insert decision
	assign pixel.ready = (state_q == ST_RUN);
	assign acc         = pixel.valid && pixel.ready;
	assign pass        = (pixel.depth_px > min_q) && (pixel.depth_px < max_q);
	assign full        = !(count_q < CAP);
	assign ins         = acc && pass && !full;
	assign count_nxt   = ins ? count_q + CW'(1) : count_q;

	// Drain finishes once the median sits in cell 0 and the output is free
	assign drain_done = (state_q == ST_DRAIN) && (shl_cnt_q == '0);
	assign load       = drain_done && (!out_vld_q || result.ready);

	assign ctl.ins = ins;
	assign ctl.shl = (state_q == ST_DRAIN) && (shl_cnt_q != '0);
	assign ctl.din = pixel.depth_px;

	rmd_chain #(
		.N  (MAX_SAMPLES),
		.CW (CW)
	) u_chain (
		.clk    (clk),
		.ctl    (ctl),
		.count  (count_q),
		.head_q (head)
	);

	// Region control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_RUN;
			count_q   <= '0;
			ovf_q     <= 1'b0;
			shl_cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_RUN: begin
					count_q <= count_nxt;
					if (acc && pass && full) begin
						ovf_q <= 1'b1;
					end
					if (acc && pixel.last_pixel) begin
						state_q   <= ST_DRAIN;
						shl_cnt_q <= count_nxt >> 1;
					end
				end
				ST_DRAIN: begin
					if (shl_cnt_q != '0) begin
						shl_cnt_q <= shl_cnt_q - CW'(1);
					end else if (load) begin
						state_q <= ST_RUN;
						count_q <= '0;
						ovf_q   <= 1'b0;
					end
				end
				default: state_q <= ST_RUN;
			endcase
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load) begin
			out_vld_q <= 1'b1;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_med_q <= (count_q == '0) ? '0 : head;
			out_has_q <= (count_q != '0);
			out_cnt_q <= KW'(count_q);
			out_ovf_q <= ovf_q;
		end
	end

	assign result.valid           = out_vld_q;
	assign result.median_depth_mm = out_med_q;
	assign result.has_depth       = out_has_q;
	assign result.kept_count      = out_cnt_q;
	assign result.overflowed      = out_ovf_q;

endmodule

@@ sv/rmd_checker.sv @@
// Port-level checks for the ROI median depth block, bound to the top level.
module rmd_checker
	import rmd_pkg::*;
(
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input logic          in_last,
	input logic          out_valid,
	input logic          out_ready,
	input logic [DW-1:0] out_median,
	input logic          out_has,
	input logic [KW-1:0] out_count
);

	// A waiting result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_median)
			&& $stable(out_count) && $stable(out_has))
		else $error("result changed while stalled");

	// Depth flag agrees with the count
	a_has_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_has == (out_count != '0)))
		else $error("has_depth disagrees with kept_count");

	// An empty region reports zero depth
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_has |-> out_median == '0)
		else $error("nonzero median without depth");

	// The last pixel of a region starts the drain, input pauses
	a_last_pause: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last |=> !in_ready)
		else $error("input taken right after last pixel");

endmodule

bind roi_median_depth rmd_checker u_rmd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (pixel.valid),
	.in_ready   (pixel.ready),
	.in_last    (pixel.last_pixel),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.out_median (result.median_depth_mm),
	.out_has    (result.has_depth),
	.out_count  (result.kept_count)
);
